>>> rtl/core/s256bh_pkg.sv
`timescale 1ns / 1ps
package s256bh_pkg;

    localparam logic [1:0] CMD_APPEND  = 2'd0;
    localparam logic [1:0] CMD_DIGEST  = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
    } in_req_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        last_word;
    } out_req_t;

    typedef logic [31:0] word_t;

    function automatic word_t rotr(input word_t v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    function automatic word_t init_hash(input logic [2:0] i);
        word_t r;
        unique case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    function automatic word_t round_k(input logic [5:0] t);
        word_t k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[t];
    endfunction

endpackage

>>> rtl/core/s256bh_ram.sv
`timescale 1ns / 1ps
module s256bh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/s256bh_round.sv
`timescale 1ns / 1ps
module s256bh_round
    import s256bh_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  word_t       init [8],
    input  logic        shift_en,
    input  word_t       w_in,
    input  logic        rnd_en,
    input  logic [5:0]  t,
    output word_t       w_cur,
    output word_t       v [8]
);

    word_t win_reg [16];
    word_t v_reg [8];
    word_t s0;
    word_t s1;
    word_t w_new;
    word_t big0;
    word_t big1;
    word_t ch;
    word_t maj;
    word_t t1;
    word_t t2;

    always_comb
    begin
        s0 = rotr(win_reg[1], 7) ^ rotr(win_reg[1], 18) ^ (win_reg[1] >> 3);
        s1 = rotr(win_reg[14], 17) ^ rotr(win_reg[14], 19) ^ (win_reg[14] >> 10);
        w_new = win_reg[0] + s0 + win_reg[9] + s1;
        w_cur = win_reg[0];
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + big1 + ch + round_k(t) + w_cur;
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2 = big0 + maj;
        v = v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_in;
        end
        else if (rnd_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[15] <= w_new;
        end
        if (load)
        begin
            v_reg <= init;
        end
        else if (rnd_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

endmodule

>>> rtl/core/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream. Requests carry cmd (0 append byte, 1 digest,
// 2 restart, 3 ignored). Bytes land in a 64-entry byte RAM; the 64th byte of a
// block starts a compression: 64 reads of the byte RAM to build the sixteen
// message words, then 64 rounds through one round unit, then the eight-word
// chaining update. Digest builds the padded block(s) from the same RAM on the
// fly, takes one or two such compressions on a copy of the chaining words, and
// returns eight words, word 0 first, last_word on the eighth; the hash state is
// kept so more bytes may follow. Appends without a full block only store the
// byte; input stall stays high while a request is in work.
`timescale 1ns / 1ps
module sha256_byte_stream_hasher
    import s256bh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_req_t  in_data,
    input  logic     in_valid,
    output logic     in_stall,
    output out_req_t out_data,
    output logic     out_valid,
    input  logic     out_stall
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]  state_reg;
    logic [2:0]  state_next;
    logic [5:0]  fill_reg;
    logic [60:0] total_reg;
    word_t       chain_reg [8];
    word_t       work_reg [8];
    logic        dig_reg;
    logic        second_reg;
    logic        two_reg;
    logic [6:0]  cnt_reg;
    logic [5:0]  rcnt_reg;
    logic [2:0]  ocnt_reg;
    word_t       acc_reg;
    logic [5:0]  bpos_reg;
    logic        rvalid_reg;

    logic        accept;
    logic        ram_we;
    logic [5:0]  ram_raddr;
    logic [7:0]  ram_rdata;
    logic [7:0]  pad_byte;
    logic [6:0]  gpos;
    logic [63:0] bits;
    word_t       w_cur;
    word_t       v [8];
    logic        shift_en;
    logic        rnd_en;
    logic        load;
    word_t       acc_next;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign ram_we   = accept && (in_data.cmd == CMD_APPEND);
    assign ram_raddr = cnt_reg[5:0];

    s256bh_ram #(.WIDTH(8), .DEPTH(64)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg),
        .wdata (in_data.data_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign bits = {total_reg, 3'b000};
    assign gpos = {second_reg, bpos_reg};

    always_comb
    begin
        priority if (!dig_reg)
        begin
            pad_byte = ram_rdata;
        end
        else if (gpos < {1'b0, fill_reg})
        begin
            pad_byte = ram_rdata;
        end
        else if (gpos == {1'b0, fill_reg})
        begin
            pad_byte = 8'h80;
        end
        else if (bpos_reg >= 6'd56 && (second_reg || !two_reg))
        begin
            pad_byte = bits[8*(7 - (bpos_reg - 6'd56)) +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
        acc_next = {acc_reg[23:0], pad_byte};
    end

    assign shift_en = (state_reg == ST_LOAD) && rvalid_reg && (bpos_reg[1:0] == 2'd3);
    assign rnd_en   = (state_reg == ST_ROUND);
    assign load     = (state_reg == ST_LOAD) && (cnt_reg == 7'd0);

    s256bh_round u_round (
        .clk      (clk),
        .load     (load),
        .init     (work_reg),
        .shift_en (shift_en),
        .w_in     (acc_next),
        .rnd_en   (rnd_en),
        .t        (rcnt_reg),
        .w_cur    (w_cur),
        .v        (v)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && in_data.cmd == CMD_DIGEST)
                begin
                    state_next = ST_LOAD;
                end
                else if (accept && in_data.cmd == CMD_APPEND && fill_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (rvalid_reg && bpos_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (rcnt_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                priority if (dig_reg && two_reg && !second_reg)
                begin
                    state_next = ST_LOAD;
                end
                else if (dig_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!out_stall && ocnt_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            total_reg  <= '0;
            dig_reg    <= 1'b0;
            second_reg <= 1'b0;
            two_reg    <= 1'b0;
            cnt_reg    <= '0;
            rcnt_reg   <= '0;
            ocnt_reg   <= '0;
            bpos_reg   <= '0;
            rvalid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= init_hash(3'(i));
            end
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg    <= '0;
                    rcnt_reg   <= '0;
                    ocnt_reg   <= '0;
                    rvalid_reg <= 1'b0;
                    second_reg <= 1'b0;
                    if (accept)
                    begin
                        unique case (in_data.cmd)
                            CMD_APPEND:
                            begin
                                fill_reg  <= fill_reg + 6'd1;
                                total_reg <= total_reg + 61'd1;
                                dig_reg   <= 1'b0;
                            end
                            CMD_DIGEST:
                            begin
                                dig_reg <= 1'b1;
                                two_reg <= (fill_reg >= 6'd56);
                            end
                            CMD_RESTART:
                            begin
                                fill_reg  <= '0;
                                total_reg <= '0;
                                for (int i = 0; i < 8; i++)
                                begin
                                    chain_reg[i] <= init_hash(3'(i));
                                end
                            end
                            default:
                            begin
                                dig_reg <= dig_reg;
                            end
                        endcase
                    end
                end
                ST_LOAD:
                begin
                    if (cnt_reg != 7'd64)
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                    rvalid_reg <= (cnt_reg != 7'd64);
                    bpos_reg   <= cnt_reg[5:0];
                    if (rvalid_reg)
                    begin
                        acc_reg <= acc_next;
                    end
                    if (rvalid_reg && bpos_reg == 6'd63)
                    begin
                        rvalid_reg <= 1'b0;
                        rcnt_reg   <= '0;
                    end
                end
                ST_ROUND:
                begin
                    rcnt_reg <= rcnt_reg + 6'd1;
                end
                ST_ADD:
                begin
                    cnt_reg    <= '0;
                    rvalid_reg <= 1'b0;
                    second_reg <= 1'b1;
                    if (!dig_reg)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_reg[i] <= chain_reg[i] + v[i];
                        end
                    end
                end
                ST_OUT:
                begin
                    if (!out_stall)
                    begin
                        ocnt_reg <= ocnt_reg + 3'd1;
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            work_reg <= chain_reg;
            if (accept && in_data.cmd == CMD_APPEND && fill_reg == 6'd63)
            begin
                work_reg <= chain_reg;
            end
        end
        else if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= work_reg[i] + v[i];
            end
        end
    end

    assign out_valid            = (state_reg == ST_OUT);
    assign out_data.digest_word = work_reg[ocnt_reg];
    assign out_data.last_word   = (ocnt_reg == 3'd7);

endmodule

>>> rtl/core/s256bh_checker.sv
`timescale 1ns / 1ps
module s256bh_checker
    import s256bh_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input in_req_t  in_data,
    input logic     in_valid,
    input logic     in_stall,
    input out_req_t out_data,
    input logic     out_valid,
    input logic     out_stall
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("request taken while results pending");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last_word |=> !out_valid)
        else $error("result after last word");

    a_digest_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.cmd == CMD_DIGEST |=> in_stall)
        else $error("digest not in work");

endmodule

bind sha256_byte_stream_hasher s256bh_checker u_s256bh_checker (.*);

>>> tb/sv/sha256_byte_stream_hasher_checker.sv
`timescale 1ns / 1ps
module sha256_byte_stream_hasher_checker
    import s256bh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  in_req_t  in_data,
    input  logic     in_valid,
    input  logic     in_stall,
    input  out_req_t out_data,
    input  logic     out_valid,
    input  logic     out_stall,
    output int       fail_count,
    output int       pending_words,
    output int       digests_seen
);

    logic [31:0] iv_words [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
                                  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    logic [31:0] k_table [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    logic [31:0] chain [8];
    logic [7:0]  pending_bytes [64];
    logic [5:0]  fill;
    logic [60:0] msg_bytes;
    out_req_t    expected_words [$];

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    task automatic sha_compress(inout logic [31:0] st [8], input logic [7:0] blk [64]);
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = w[t-16] + w[t-7]
                 + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
                 + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
        v = st;
        for (int t = 0; t < 64; t++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k_table[t] + w[t];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            st[i] = st[i] + v[i];
    endtask

    task automatic predict_digest();
        logic [7:0]  pad [128];
        logic [7:0]  half [64];
        logic [31:0] st [8];
        logic [63:0] bits;
        int          len;
        out_req_t    r;
        bits = {msg_bytes, 3'b000};
        len = (fill < 56) ? 64 : 128;
        for (int i = 0; i < 128; i++)
            pad[i] = (i < fill) ? pending_bytes[i] : 8'h00;
        pad[fill] = 8'h80;
        for (int k = 0; k < 8; k++)
            pad[len-1-k] = bits[8*k +: 8];
        st = chain;
        for (int i = 0; i < 64; i++)
            half[i] = pad[i];
        sha_compress(st, half);
        if (len == 128)
        begin
            for (int i = 0; i < 64; i++)
                half[i] = pad[64+i];
            sha_compress(st, half);
        end
        for (int k = 0; k < 8; k++)
        begin
            r.digest_word = st[k];
            r.last_word = (k == 7);
            expected_words.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_req_t exp_w;
        if (!rst_n)
        begin
            chain = iv_words;
            fill = '0;
            msg_bytes = '0;
            expected_words.delete();
            fail_count = 0;
            digests_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, actual %h/%b", $time,
                             out_data.digest_word, out_data.last_word);
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (exp_w.last_word)
                        digests_seen++;
                    if (exp_w.digest_word !== out_data.digest_word)
                    begin
                        fail_count++;
                        $display("%0t: digest_word expected %h actual %h", $time,
                                 exp_w.digest_word, out_data.digest_word);
                    end
                    if (exp_w.last_word !== out_data.last_word)
                    begin
                        fail_count++;
                        $display("%0t: last_word expected %b actual %b", $time,
                                 exp_w.last_word, out_data.last_word);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                case (in_data.cmd)
                    CMD_APPEND:
                    begin
                        pending_bytes[fill] = in_data.data_byte;
                        msg_bytes = msg_bytes + 1;
                        if (fill == 6'd63)
                            sha_compress(chain, pending_bytes);
                        fill = fill + 1;
                    end
                    CMD_DIGEST: predict_digest();
                    CMD_RESTART:
                    begin
                        chain = iv_words;
                        fill = '0;
                        msg_bytes = '0;
                    end
                    default: ;
                endcase
            end
        end
        pending_words = expected_words.size();
    end

endmodule

>>> tb/sv/tb_sha256_byte_stream_hasher.sv
`timescale 1ns / 1ps
module tb_sha256_byte_stream_hasher;
    import s256bh_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    in_req_t  in_data = '0;
    logic     in_valid = 1'b0;
    logic     in_stall;
    out_req_t out_data;
    logic     out_valid;
    logic     out_stall = 1'b0;
    int       fail_count;
    int       pending_words;
    int       digests_seen;
    int       cycles = 0;
    int       sent = 0;
    bit       quiet = 1'b0;
    bit       hold_off = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sha256_byte_stream_hasher dut (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
    );

    sha256_byte_stream_hasher_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_data(in_data), .in_valid(in_valid), .in_stall(in_stall),
        .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall),
        .fail_count(fail_count), .pending_words(pending_words),
        .digests_seen(digests_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall bursts, plus one long hold-off
    initial
    begin
        int burst;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                for (int i = 0; i < 600; i++)
                    @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (burst - 1) @(posedge clk);
                @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_request(logic [1:0] cmd, logic [7:0] b);
        int gap;
        if (!quiet && sent > 0 && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{cmd: cmd, data_byte: b};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_bytes(int n);
        for (int i = 0; i < n; i++)
            send_request(CMD_APPEND, 8'($urandom));
    endtask

    initial
    begin
        int pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // empty message, all-ones and zero bytes, ignored commands
        send_request(CMD_DIGEST, 8'hff);
        send_request(CMD_APPEND, 8'h00);
        send_request(CMD_APPEND, 8'hff);
        send_request(CMD_UNUSED, 8'h5a);
        send_request(CMD_DIGEST, 8'h00);
        send_request(CMD_RESTART, 8'haa);
        send_request(CMD_APPEND, 8'h61);
        send_request(CMD_APPEND, 8'h62);
        send_request(CMD_APPEND, 8'h63);
        send_request(CMD_DIGEST, 8'h55);
        send_request(CMD_DIGEST, 8'h00);
        send_request(CMD_RESTART, 8'h00);
        // 55 and 56 pending bytes: one and two padding blocks
        send_bytes(55);
        send_request(CMD_DIGEST, 8'h00);
        send_bytes(1);
        send_request(CMD_DIGEST, 8'h00);
        send_bytes(7);
        send_request(CMD_DIGEST, 8'h00);
        send_bytes(1);
        send_request(CMD_DIGEST, 8'h00);
        // digests of short additions behind a long output hold-off
        hold_off = 1'b1;
        for (int d = 0; d < 6; d++)
        begin
            send_bytes(3);
            send_request(CMD_DIGEST, 8'h00);
        end
        while (sent < 460)
        begin
            if (sent > 400)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_bytes($urandom_range(1, 20));
            else if (pick < 90)
                send_request(CMD_DIGEST, 8'($urandom));
            else if (pick < 96)
                send_request(CMD_RESTART, 8'($urandom));
            else
                send_request(CMD_UNUSED, 8'($urandom));
        end
        in_valid <= 1'b0;
        while (pending_words != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        $display("ran %0d requests over %0d cycles, %0d digests checked", sent, cycles,
                 digests_seen);
        $display("covered empty, short, one- and two-block padding and restarts");
        if (fail_count == 0 && pending_words == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
